// ----- rtl/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, types and helper functions of the first-fit bitmap
// allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int MAX_MAP_BLOCKS = 8;
  localparam int BLOCK_BYTES    = 1024;

  localparam int ADDR_W      = 13;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CAPACITY    = (MAX_MAP_BLOCKS * BLOCK_BYTES < STORE_DEPTH) ?
                               MAX_MAP_BLOCKS * BLOCK_BYTES : STORE_DEPTH;
  localparam int LIMIT_W     = ADDR_W + 1;
  localparam int BIT_W       = 3;
  localparam int IDX_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int CFG_W       = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_FULL = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } scan_mem_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } scan_status_t;

  // lowest clear bit of a byte that is not full
  function automatic logic [BIT_W-1:0] first_zero(input logic [BYTE_W-1:0] b);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!b[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // bytes covered by a scan for a given block count
  function automatic logic [LIMIT_W-1:0] scan_limit(input logic [CFG_W-1:0] mb);
    int blocks;
    int bytes;
    blocks = int'(mb);
    if (blocks > MAX_MAP_BLOCKS) blocks = MAX_MAP_BLOCKS;
    bytes = blocks * BLOCK_BYTES;
    if (bytes > CAPACITY) bytes = CAPACITY;
    return LIMIT_W'(bytes);
  endfunction

endpackage

// ----- rtl/bffa_ram.sv -----
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bffa_scan.sv -----
// ----------------------------------------------------------------------------
// bffa_scan
// Scan engine: walks the map one byte a cycle through the RAM read port and
// tests each byte with one shared compare and priority unit.
// ----------------------------------------------------------------------------
module bffa_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [bffa_pkg::LIMIT_W-1:0]     limit,
  input  logic [bffa_pkg::BYTE_W-1:0]      rdata,
  output bffa_pkg::scan_mem_t              mem,
  output bffa_pkg::scan_status_t           status
);

  logic                          active_r, active_nxt;
  logic [bffa_pkg::LIMIT_W-1:0]  issue_r, issue_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [bffa_pkg::ADDR_W-1:0]   chk_addr_r, chk_addr_nxt;
  logic                          hit;
  logic                          exhausted;
  logic                          more;
  logic [bffa_pkg::BIT_W-1:0]    bit_pos;
  logic [bffa_pkg::BYTE_W-1:0]   bit_mask;

  assign hit       = active_r && chk_vld_r && (rdata != bffa_pkg::BYTE_FULL);
  assign exhausted = active_r && !chk_vld_r && (issue_r >= limit);
  assign more      = active_r && !hit && (issue_r < limit);
  assign bit_pos   = bffa_pkg::first_zero(rdata);
  assign bit_mask  = bffa_pkg::BYTE_W'(1) << bit_pos;

  always_comb begin
    active_nxt   = active_r;
    issue_nxt    = issue_r;
    chk_vld_nxt  = 1'b0;
    chk_addr_nxt = chk_addr_r;
    if (go) begin
      active_nxt = 1'b1;
      issue_nxt  = '0;
    end else if (hit || exhausted) begin
      active_nxt = 1'b0;
    end else if (more) begin
      chk_vld_nxt  = 1'b1;
      chk_addr_nxt = issue_r[bffa_pkg::ADDR_W-1:0];
      issue_nxt    = issue_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      chk_vld_r <= 1'b0;
      issue_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      chk_vld_r <= chk_vld_nxt;
      issue_r   <= issue_nxt;
    end
    chk_addr_r <= chk_addr_nxt;
  end

  assign mem.rd_en   = more && !go;
  assign mem.rd_addr = issue_r[bffa_pkg::ADDR_W-1:0];
  assign mem.wr_en   = hit;
  assign mem.wr_addr = chk_addr_r;
  assign mem.wr_data = rdata | bit_mask;

  assign status.done  = hit || exhausted;
  assign status.found = hit;
  assign status.index = hit ? bffa_pkg::IDX_W'({chk_addr_r, bit_pos}) : '0;

endmodule

// ----- rtl/bitmap_first_free_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit bitmap allocator over a resident byte map held in block RAM.
//
// Input items are accepted on a rising edge with start high and busy low.
// func selects load (write one map byte), allocate (find, set and report the
// lowest clear bit) or read (return one map byte). Every item gives exactly
// one result, shown for one cycle with out_valid high; the receiver cannot
// stall it. Configuration (map_blocks) is written over cfg_valid/cfg_ready,
// ready whenever no item is in progress.
// A load gives its result the cycle after acceptance and never raises busy;
// a read passes through the registered RAM read and the READ state first.
// An allocate walks the map one byte per cycle through the single RAM read
// port and reports the first clear bit it finds, or a miss once L bytes are
// scanned, L being map_blocks*1024 capped at 8192; with map_blocks 0 it scans
// nothing and reports a miss. busy stays high for that whole walk.
// Reset clears the control state and sets map_blocks to 1; the map contents
// are undefined until loaded and no clearing pass runs.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bffa_pkg::FUNC_W-1:0]   in_func,
  input  logic [bffa_pkg::ADDR_W-1:0]   in_byte_addr,
  input  logic [bffa_pkg::BYTE_W-1:0]   in_byte_value,
  output logic                          out_valid,
  output logic [bffa_pkg::IDX_W-1:0]    out_alloc_index,
  output logic                          out_found,
  output logic [bffa_pkg::BYTE_W-1:0]   out_read_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bffa_pkg::CFG_W-1:0]    cfg_map_blocks
);

  bffa_pkg::state_t              state_r, state_nxt;
  logic [bffa_pkg::CFG_W-1:0]    map_blocks_r;
  logic                          rd_ok_r, rd_ok_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bffa_pkg::IDX_W-1:0]    out_index_r, out_index_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [bffa_pkg::BYTE_W-1:0]   out_rv_r, out_rv_nxt;

  logic                          accept;
  logic                          addr_ok;
  logic                          scan_go;
  logic                          load_we;
  logic                          read_re;
  logic [bffa_pkg::BYTE_W-1:0]   ram_rdata;
  logic                          ram_we;
  logic [bffa_pkg::ADDR_W-1:0]   ram_waddr;
  logic [bffa_pkg::BYTE_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [bffa_pkg::ADDR_W-1:0]   ram_raddr;
  bffa_pkg::scan_mem_t           scan_mem;
  bffa_pkg::scan_status_t        scan_st;

  assign busy      = (state_r != bffa_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign addr_ok   = ({1'b0, in_byte_addr} < bffa_pkg::LIMIT_W'(bffa_pkg::CAPACITY));
  assign load_we   = accept && (in_func == bffa_pkg::FUNC_LOAD) && addr_ok;
  assign read_re   = accept && (in_func == bffa_pkg::FUNC_READ);

  always_comb begin
    state_nxt     = state_r;
    scan_go       = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    out_rv_nxt    = out_rv_r;
    unique case (state_r)
      bffa_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            bffa_pkg::FUNC_ALLOC: begin
              scan_go   = 1'b1;
              state_nxt = bffa_pkg::ST_SCAN;
            end
            bffa_pkg::FUNC_READ: begin
              rd_ok_nxt = addr_ok;
              state_nxt = bffa_pkg::ST_READ;
            end
            default: begin
              // load and unused codes answer at once with zeros
              out_valid_nxt = 1'b1;
              out_index_nxt = '0;
              out_found_nxt = 1'b0;
              out_rv_nxt    = '0;
            end
          endcase
        end
      end
      bffa_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = '0;
        out_found_nxt = 1'b0;
        out_rv_nxt    = rd_ok_r ? ram_rdata : '0;
        state_nxt     = bffa_pkg::ST_IDLE;
      end
      bffa_pkg::ST_SCAN: begin
        if (scan_st.done) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = scan_st.index;
          out_found_nxt = scan_st.found;
          out_rv_nxt    = '0;
          state_nxt     = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bffa_pkg::ST_IDLE;
      map_blocks_r <= bffa_pkg::CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        map_blocks_r <= cfg_map_blocks;
      end
    end
    rd_ok_r     <= rd_ok_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
    out_rv_r    <= out_rv_nxt;
  end

  // ram port sharing between host items and the scan engine
  assign ram_we    = load_we || scan_mem.wr_en;
  assign ram_waddr = load_we ? in_byte_addr : scan_mem.wr_addr;
  assign ram_wdata = load_we ? in_byte_value : scan_mem.wr_data;
  assign ram_re    = read_re || scan_mem.rd_en;
  assign ram_raddr = read_re ? in_byte_addr : scan_mem.rd_addr;

  bffa_ram #(
    .WIDTH (bffa_pkg::BYTE_W),
    .DEPTH (bffa_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bffa_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (scan_go),
    .limit  (bffa_pkg::scan_limit(map_blocks_r)),
    .rdata  (ram_rdata),
    .mem    (scan_mem),
    .status (scan_st)
  );

  assign out_valid       = out_valid_r;
  assign out_alloc_index = out_index_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_rv_r;

endmodule

// ----- rtl/bffa_chk.sv -----
// ----------------------------------------------------------------------------
// bffa_chk
// Port-level checker for the first-fit bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
module bffa_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [bffa_pkg::FUNC_W-1:0]   in_func,
  input  logic                          out_valid,
  input  logic [bffa_pkg::IDX_W-1:0]    out_alloc_index,
  input  logic                          out_found,
  input  logic [bffa_pkg::BYTE_W-1:0]   out_read_value
);

  // an accepted allocate always raises busy
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == bffa_pkg::FUNC_ALLOC |=> busy)
    else $error("allocate accepted without going busy");

  // finishing an item that raised busy always shows its result
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_found_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_read_value == '0)
    else $error("allocate result carries read data");

  a_miss_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_alloc_index == '0)
    else $error("nonzero index without allocation");

endmodule

bind bitmap_first_free_allocator bffa_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_alloc_index (out_alloc_index),
  .out_found       (out_found),
  .out_read_value  (out_read_value)
);

// ----- dv/bitmap_first_free_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_checker
// Watches the item, result and map_blocks channels of the allocator. Keeps its
// own copy of the byte map and of map_blocks, works out the answer to every
// accepted item and compares each result strobe, field by field, with the
// oldest outstanding answer. Hands the error and outstanding counts upward.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_checker
  import bffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ADDR_W-1:0] in_byte_addr,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              out_valid,
  input  logic [IDX_W-1:0]  out_alloc_index,
  input  logic              out_found,
  input  logic [BYTE_W-1:0] out_read_value,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_map_blocks,
  output int                error_count,
  output int                pending_count
);

  typedef struct packed {
    logic [IDX_W-1:0]  alloc_index;
    logic              found;
    logic [BYTE_W-1:0] read_value;
  } answer_t;

  answer_t          answers_due[$];
  logic [BYTE_W-1:0] map_copy [CAPACITY];
  logic [CFG_W-1:0]  blocks_setting;

  function automatic answer_t answer_item(input logic [FUNC_W-1:0] f,
                                          input logic [ADDR_W-1:0] a,
                                          input logic [BYTE_W-1:0] v);
    answer_t ans;
    int      span;
    ans = '0;
    case (f)
      FUNC_LOAD: begin
        if (int'(a) < CAPACITY) map_copy[a] = v;
      end
      FUNC_ALLOC: begin
        span = int'(blocks_setting);
        if (span > MAX_MAP_BLOCKS) span = MAX_MAP_BLOCKS;
        span = span * BLOCK_BYTES;
        if (span > CAPACITY) span = CAPACITY;
        // first fit: lowest byte, then lowest bit
        for (int b = 0; b < span && !ans.found; b++) begin
          for (int k = 0; k < BYTE_W && !ans.found; k++) begin
            if (!map_copy[b][k]) begin
              map_copy[b][k]  = 1'b1;
              ans.alloc_index = IDX_W'(b * BYTE_W + k);
              ans.found       = 1'b1;
            end
          end
        end
      end
      FUNC_READ: begin
        if (int'(a) < CAPACITY) ans.read_value = map_copy[a];
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t due;
    if (!rst_n) begin
      blocks_setting = 4'd1;
      for (int i = 0; i < CAPACITY; i++) map_copy[i] = '0;
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $error("result with no item outstanding: alloc_index %0d found %0d read_value %0d",
                 out_alloc_index, out_found, out_read_value);
          error_count++;
        end else begin
          due = answers_due.pop_front();
          if (out_alloc_index !== due.alloc_index) begin
            $error("alloc_index: expected %0d, actual %0d", due.alloc_index, out_alloc_index);
            error_count++;
          end
          if (out_found !== due.found) begin
            $error("found: expected %0d, actual %0d", due.found, out_found);
            error_count++;
          end
          if (out_read_value !== due.read_value) begin
            $error("read_value: expected 0x%02h, actual 0x%02h", due.read_value, out_read_value);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) blocks_setting = cfg_map_blocks;
      if (start && !busy) answers_due.push_back(answer_item(in_func, in_byte_addr, in_byte_value));
    end
    pending_count = answers_due.size();
  end

endmodule

// ----- dv/bitmap_first_free_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_tb
// Drives the first-fit bitmap allocator: fills the first bytes of the map,
// runs a short directed sequence (highest bit of the loaded bytes, zero and
// oversized map_blocks, unused func code), then random phases with different
// map_blocks settings and sender idling. Allocates are only issued when the
// scan stays inside bytes already loaded. The checker beside the block does
// all comparisons.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_tb;
  import bffa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;
  localparam int                CYCLE_LIMIT = 20_000_000;
  localparam int                PHASES      = 6;
  localparam int                PHASE_ITEMS = 88;
  localparam int                FILL_BYTES  = 32;
  localparam int                TAIL_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [ADDR_W-1:0] in_byte_addr;
  logic [BYTE_W-1:0] in_byte_value;
  logic              out_valid;
  logic [IDX_W-1:0]  out_alloc_index;
  logic              out_found;
  logic [BYTE_W-1:0] out_read_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_map_blocks;
  int                error_count;
  int                pending_count;
  int                cycles;

  // map as seen by the stimulus, used to keep scans over loaded bytes only
  bit [BYTE_W-1:0] stim_map    [STORE_DEPTH];
  bit              stim_loaded [STORE_DEPTH];
  int              prefix;
  logic [CFG_W-1:0] stim_blocks;

  bitmap_first_free_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_byte_addr    (in_byte_addr),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_alloc_index (out_alloc_index),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_map_blocks  (cfg_map_blocks)
  );

  bitmap_first_free_allocator_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_byte_addr    (in_byte_addr),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_alloc_index (out_alloc_index),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_map_blocks  (cfg_map_blocks),
    .error_count     (error_count),
    .pending_count   (pending_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int span_bytes();
    int span;
    span = int'(stim_blocks);
    if (span > MAX_MAP_BLOCKS) span = MAX_MAP_BLOCKS;
    span = span * BLOCK_BYTES;
    return (span > CAPACITY) ? CAPACITY : span;
  endfunction

  // true when the scan stops before reaching any byte never loaded
  function automatic bit alloc_safe();
    if (span_bytes() <= prefix) return 1'b1;
    for (int b = 0; b < prefix; b++) begin
      if (stim_map[b] != BYTE_FULL) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic drive_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                            input logic [BYTE_W-1:0] v);
    int span;
    if (f == FUNC_LOAD) begin
      stim_map[a]    = v;
      stim_loaded[a] = 1'b1;
      while (prefix < STORE_DEPTH && stim_loaded[prefix]) prefix++;
    end else if (f == FUNC_ALLOC) begin
      span = span_bytes();
      for (int b = 0; b < span; b++) begin
        if (stim_map[b] != BYTE_FULL) begin
          stim_map[b] = stim_map[b] | (stim_map[b] + 8'd1);
          break;
        end
      end
    end
    start         <= 1'b1;
    in_func       <= f;
    in_byte_addr  <= a;
    in_byte_value <= v;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_map_blocks <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid   <= 1'b0;
    stim_blocks = v;
  endtask

  task automatic random_item();
    int                r;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] v;
    r = $urandom_range(99);
    a = ADDR_W'($urandom_range(STORE_DEPTH - 1));
    v = ($urandom_range(99) < 70) ? BYTE_FULL : BYTE_W'($urandom);
    if (r < 40) begin
      r = $urandom_range(99);
      if (r < 60) a = ADDR_W'($urandom_range(prefix - 1));
      else if (r < 75 && prefix < STORE_DEPTH) a = ADDR_W'(prefix);
      drive_item(FUNC_LOAD, a, v);
    end else if (r < 80) begin
      if (alloc_safe()) begin
        drive_item(FUNC_ALLOC, a, v);
      end else begin
        // open a hole inside the loaded bytes so the next scan stops there
        v = BYTE_W'($urandom) & ~(8'd1 << $urandom_range(BYTE_W - 1));
        drive_item(FUNC_LOAD, ADDR_W'($urandom_range(prefix - 1)), v);
      end
    end else if (r < 95) begin
      if (!stim_loaded[a] || $urandom_range(1) == 0) a = ADDR_W'($urandom_range(prefix - 1));
      drive_item(FUNC_READ, a, v);
    end else begin
      drive_item(FUNC_NONE, a, v);
    end
  endtask

  initial begin
    int               idle_pct;
    logic [CFG_W-1:0] blocks;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_func        <= FUNC_LOAD;
    in_byte_addr   <= '0;
    in_byte_value  <= '0;
    cfg_valid      <= 1'b0;
    cfg_map_blocks <= '0;
    prefix         = 0;
    stim_blocks    = 4'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_blocks(4'd1);
    for (int i = 0; i < FILL_BYTES; i++) drive_item(FUNC_LOAD, ADDR_W'(i), BYTE_FULL);

    drive_item(FUNC_LOAD, 13'd8191, 8'hA5);
    drive_item(FUNC_LOAD, 13'd4096, 8'h5A);
    drive_item(FUNC_READ, 13'd0, 8'h00);
    drive_item(FUNC_READ, 13'd31, 8'h00);
    drive_item(FUNC_READ, 13'd8191, 8'hFF);
    drive_item(FUNC_READ, 13'd4096, 8'h00);
    // highest bit of the loaded bytes
    drive_item(FUNC_LOAD, 13'd31, 8'h7F);
    drive_item(FUNC_ALLOC, 13'd0, 8'h00);
    drive_item(FUNC_NONE, 13'd8191, 8'hFF);
    drive_item(FUNC_LOAD, 13'd5, 8'h00);
    drive_item(FUNC_LOAD, 13'd1, 8'hFE);
    drive_item(FUNC_ALLOC, 13'd0, 8'h00);
    drive_item(FUNC_ALLOC, 13'd0, 8'h00);
    drive_item(FUNC_READ, 13'd5, 8'h00);
    drive_item(FUNC_READ, 13'd1, 8'h00);
    // zero map size scans nothing
    go_quiet();
    write_blocks(4'd0);
    drive_item(FUNC_ALLOC, 13'd0, 8'h00);
    // oversized map_blocks saturates
    go_quiet();
    write_blocks(4'd15);
    drive_item(FUNC_ALLOC, 13'd0, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       blocks = 4'd8;
        1:       blocks = 4'd1;
        2:       blocks = 4'd15;
        3:       blocks = 4'd2;
        4:       blocks = 4'd0;
        default: blocks = CFG_W'($urandom_range(15));
      endcase
      case (ph % 4)
        1:       idle_pct = 51;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      go_quiet();
      write_blocks(blocks);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 3) begin
          go_quiet();
        end else begin
          while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
          end
        end
        random_item();
      end
    end

    go_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
